// ===== src/cau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg: shared types and helpers for the complex arithmetic unit
// Holds the item structs, operation codes and fixed-point helpers.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int W     = 32;
    localparam int FRAC  = 16;
    localparam int QW    = W + FRAC;          // dividend magnitude width
    localparam int QSTEP = 4;                 // quotient bits per stage
    localparam int NSTG  = QW / QSTEP;        // divider stages

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_PAR = 3'd4;

    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [2:0]          req_type;
        logic signed [W-1:0] a_re;
        logic signed [W-1:0] a_im;
        logic signed [W-1:0] b_re;
        logic signed [W-1:0] b_im;
    } in_item_t;

    typedef struct packed {
        logic signed [W-1:0] res_re;
        logic signed [W-1:0] res_im;
        logic                div_by_zero;
        logic                overflow;
    } out_item_t;

    // Work handed from the front to the back: numerators, denominator, mode
    typedef struct packed {
        logic                bypass;   // result already final
        logic signed [W-1:0] nr;
        logic signed [W-1:0] ni;
        logic signed [W-1:0] den;
        logic signed [W-1:0] pre_re;
        logic signed [W-1:0] pre_im;
        logic                dz;
        logic                ovf;
    } job_t;

    // Saturate a 34-bit signed value to the word
    function automatic logic signed [W-1:0] sat34(input logic signed [W+1:0] x,
                                                  inout logic ovf);
        logic signed [W+1:0] hi;
        logic signed [W+1:0] lo;
        hi = {{2{1'b0}}, WMAX};
        lo = {{2{1'b1}}, WMIN};
        if (x > hi) begin
            ovf = 1'b1;
            return WMAX;
        end
        if (x < lo) begin
            ovf = 1'b1;
            return WMIN;
        end
        return x[W-1:0];
    endfunction

    // Saturate a shifted product to the word
    function automatic logic signed [W-1:0] satp(input logic signed [2*W-1:0] p,
                                                 inout logic ovf);
        logic signed [2*W-1:0] s;
        logic signed [2*W-1:0] hi;
        logic signed [2*W-1:0] lo;
        s  = p >>> FRAC;
        hi = {{W{1'b0}}, WMAX};
        lo = {{W{1'b1}}, WMIN};
        if (s > hi) begin
            ovf = 1'b1;
            return WMAX;
        end
        if (s < lo) begin
            ovf = 1'b1;
            return WMIN;
        end
        return s[W-1:0];
    endfunction

endpackage

// ===== src/cau_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front: operand stage
// Pipelined products and sums; emits a finished result or a division job.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  in_item_t in_item,
    input  logic     advance,
    output logic     job_valid,
    output job_t     job
);

    // stage 1: add/sub, raw products of a and b
    logic                  s1_v_reg;
    logic [2:0]            s1_op_reg;
    logic signed [W-1:0]   s1_sr_reg, s1_si_reg, s1_dr_reg, s1_di_reg;
    logic                  s1_so_reg, s1_do_reg;
    logic signed [2*W-1:0] s1_p_reg [4];
    logic signed [W-1:0]   s1_ar_reg, s1_ai_reg;
    logic signed [W-1:0]   s1_br_reg, s1_bi_reg;

    // stage 2: complex product, divisor choice
    logic                  s2_v_reg;
    logic [2:0]            s2_op_reg;
    logic signed [W-1:0]   s2_mr_reg, s2_mi_reg;     // numerator operand
    logic signed [W-1:0]   s2_vr_reg, s2_vi_reg;     // divisor
    logic signed [W-1:0]   s2_rr_reg, s2_ri_reg;     // final for add/sub/mul
    logic                  s2_o_reg;

    // stage 3: products of numerator and divisor
    logic                  s3_v_reg;
    logic [2:0]            s3_op_reg;
    logic signed [2*W-1:0] s3_p_reg [6];
    logic signed [W-1:0]   s3_rr_reg, s3_ri_reg;
    logic                  s3_o_reg, s3_z_reg;

    // stage 4: job register
    logic job_v_reg;
    job_t job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            job_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_v_reg  <= in_valid;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            job_v_reg <= s3_v_reg;
        end
    end

    // stage 1 data
    always_ff @(posedge clk)
    begin
        logic o;
        if (advance)
        begin
            o = 1'b0;
            s1_sr_reg <= sat34(34'(in_item.a_re) + 34'(in_item.b_re), o);
            s1_si_reg <= sat34(34'(in_item.a_im) + 34'(in_item.b_im), o);
            s1_so_reg <= o;
            o = 1'b0;
            s1_dr_reg <= sat34(34'(in_item.a_re) - 34'(in_item.b_re), o);
            s1_di_reg <= sat34(34'(in_item.a_im) - 34'(in_item.b_im), o);
            s1_do_reg <= o;
            s1_p_reg[0] <= 64'(in_item.a_re) * 64'(in_item.b_re);
            s1_p_reg[1] <= 64'(in_item.a_im) * 64'(in_item.b_im);
            s1_p_reg[2] <= 64'(in_item.a_re) * 64'(in_item.b_im);
            s1_p_reg[3] <= 64'(in_item.a_im) * 64'(in_item.b_re);
            s1_op_reg <= in_item.req_type;
            s1_ar_reg <= in_item.a_re;
            s1_ai_reg <= in_item.a_im;
            s1_br_reg <= in_item.b_re;
            s1_bi_reg <= in_item.b_im;
        end
    end

    // stage 2 data
    always_ff @(posedge clk)
    begin
        logic o;
        logic signed [W-1:0] q0, q1, q2, q3, mr, mi;
        if (advance)
        begin
            o  = 1'b0;
            q0 = satp(s1_p_reg[0], o);
            q1 = satp(s1_p_reg[1], o);
            q2 = satp(s1_p_reg[2], o);
            q3 = satp(s1_p_reg[3], o);
            mr = sat34(34'(q0) - 34'(q1), o);
            mi = sat34(34'(q2) + 34'(q3), o);
            s2_op_reg <= s1_op_reg;
            unique case (s1_op_reg)
                OP_ADD:
                begin
                    s2_rr_reg <= s1_sr_reg;
                    s2_ri_reg <= s1_si_reg;
                    s2_o_reg  <= s1_so_reg;
                end
                OP_SUB:
                begin
                    s2_rr_reg <= s1_dr_reg;
                    s2_ri_reg <= s1_di_reg;
                    s2_o_reg  <= s1_do_reg;
                end
                OP_MUL:
                begin
                    s2_rr_reg <= mr;
                    s2_ri_reg <= mi;
                    s2_o_reg  <= o;
                end
                OP_PAR:
                begin
                    s2_rr_reg <= '0;
                    s2_ri_reg <= '0;
                    s2_o_reg  <= o | s1_so_reg;
                end
                default:
                begin
                    s2_rr_reg <= '0;
                    s2_ri_reg <= '0;
                    s2_o_reg  <= 1'b0;
                end
            endcase
            // divide uses a over b, parallel uses a*b over a+b
            if (s1_op_reg == OP_PAR)
            begin
                s2_mr_reg <= mr;
                s2_mi_reg <= mi;
                s2_vr_reg <= s1_sr_reg;
                s2_vi_reg <= s1_si_reg;
            end
            else
            begin
                s2_mr_reg <= s1_ar_reg;
                s2_mi_reg <= s1_ai_reg;
                s2_vr_reg <= s1_br_reg;
                s2_vi_reg <= s1_bi_reg;
            end
        end
    end

    // stage 3 data
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_p_reg[0] <= 64'(s2_vr_reg) * 64'(s2_vr_reg);
            s3_p_reg[1] <= 64'(s2_vi_reg) * 64'(s2_vi_reg);
            s3_p_reg[2] <= 64'(s2_mr_reg) * 64'(s2_vr_reg);
            s3_p_reg[3] <= 64'(s2_mi_reg) * 64'(s2_vi_reg);
            s3_p_reg[4] <= 64'(s2_mi_reg) * 64'(s2_vr_reg);
            s3_p_reg[5] <= 64'(s2_mr_reg) * 64'(s2_vi_reg);
            s3_z_reg    <= (s2_vr_reg == '0) && (s2_vi_reg == '0);
            s3_op_reg   <= s2_op_reg;
            s3_rr_reg   <= s2_rr_reg;
            s3_ri_reg   <= s2_ri_reg;
            s3_o_reg    <= s2_o_reg;
        end
    end

    // stage 4: build the job
    always_ff @(posedge clk)
    begin
        logic o;
        logic is_div;
        logic signed [W-1:0] q0, q1, q2, q3, q4, q5;
        if (advance)
        begin
            o  = 1'b0;
            q0 = satp(s3_p_reg[0], o);
            q1 = satp(s3_p_reg[1], o);
            q2 = satp(s3_p_reg[2], o);
            q3 = satp(s3_p_reg[3], o);
            q4 = satp(s3_p_reg[4], o);
            q5 = satp(s3_p_reg[5], o);
            is_div = (s3_op_reg == OP_DIV) || (s3_op_reg == OP_PAR);
            job_reg.den    <= sat34(34'(q0) + 34'(q1), o);
            job_reg.nr     <= sat34(34'(q2) + 34'(q3), o);
            job_reg.ni     <= sat34(34'(q4) - 34'(q5), o);
            job_reg.bypass <= !is_div || s3_z_reg;
            job_reg.dz     <= is_div && s3_z_reg;
            if (is_div && s3_z_reg)
            begin
                job_reg.pre_re <= WMAX;
                job_reg.pre_im <= '0;
                job_reg.ovf    <= s3_o_reg;
            end
            else
            begin
                job_reg.pre_re <= s3_rr_reg;
                job_reg.pre_im <= s3_ri_reg;
                job_reg.ovf    <= s3_o_reg | (is_div & o);
            end
        end
    end

    assign job_valid = job_v_reg;
    assign job       = job_reg;

endmodule

// ===== src/cau_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div: pipelined signed fixed-point divider
// Radix-16 restoring division, two lanes, saturating result.
// ----------------------------------------------------------------------------
module cau_div import cau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  logic      job_valid,
    input  job_t      job,
    output logic      res_valid,
    output out_item_t res
);

    typedef struct packed {
        logic [QW-1:0] rem;
        logic [QW-1:0] quo;   // dividend bits shift out, quotient in
        logic          neg;
        logic          nz;
    } lane_t;

    typedef struct packed {
        logic [W-1:0]  dv;    // divisor magnitude
        logic          dz0;   // denominator is zero
        job_t          j;
    } ctl_t;

    lane_t lr_reg [NSTG+1];
    lane_t li_reg [NSTG+1];
    ctl_t  c_reg  [NSTG+1];
    logic  cv_reg [NSTG+1];
    logic          rv_reg;
    out_item_t     r_reg;

    function automatic lane_t lane_init(input logic signed [W-1:0] n,
                                        input logic signed [W-1:0] d);
        lane_t l;
        logic [W-1:0] mag;
        mag   = n[W-1] ? W'(-n) : n;
        l.rem = '0;
        l.quo = {mag, {FRAC{1'b0}}};
        l.neg = n[W-1] ^ d[W-1];
        l.nz  = (n != '0);
        return l;
    endfunction

    function automatic lane_t lane_step(input lane_t l, input logic [W-1:0] dv);
        lane_t o;
        logic [QW:0] t;
        o = l;
        for (int k = 0; k < QSTEP; k++)
        begin
            t = {o.rem, o.quo[QW-1]};
            o.quo = {o.quo[QW-2:0], 1'b0};
            if (t >= {{(QW+1-W){1'b0}}, dv})
            begin
                t = t - {{(QW+1-W){1'b0}}, dv};
                o.quo[0] = 1'b1;
            end
            o.rem = t[QW-1:0];
        end
        return o;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NSTG; s++)
            begin
                cv_reg[s] <= 1'b0;
            end
            rv_reg <= 1'b0;
        end
        else if (advance)
        begin
            cv_reg[0] <= job_valid;
            for (int s = 1; s <= NSTG; s++)
            begin
                cv_reg[s] <= cv_reg[s-1];
            end
            rv_reg <= cv_reg[NSTG];
        end
    end

    // load and iterate
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lr_reg[0]    <= lane_init(job.nr, job.den);
            li_reg[0]    <= lane_init(job.ni, job.den);
            c_reg[0].j   <= job;
            c_reg[0].dz0 <= (job.den == '0);
            c_reg[0].dv  <= job.den[W-1] ? W'(-job.den) : job.den;
            for (int s = 1; s <= NSTG; s++)
            begin
                lr_reg[s]    <= lane_step(lr_reg[s-1], c_reg[s-1].dv);
                li_reg[s]    <= lane_step(li_reg[s-1], c_reg[s-1].dv);
                c_reg[s].j   <= c_reg[s-1].j;
                c_reg[s].dz0 <= c_reg[s-1].dz0;
                c_reg[s].dv  <= c_reg[s-1].dv;
            end
        end
    end

    function automatic logic signed [W-1:0] lane_fin(input lane_t l, input logic dz0,
                                                     inout logic ovf);
        if (dz0)
        begin
            if (!l.nz)
            begin
                return '0;
            end
            ovf = 1'b1;
            return l.neg ? WMIN : WMAX;
        end
        if (l.neg)
        begin
            if (l.quo > {{(QW-W){1'b0}}, WMIN})
            begin
                ovf = 1'b1;
                return WMIN;
            end
            return W'(-l.quo);
        end
        if (l.quo > {{(QW-W){1'b0}}, WMAX})
        begin
            ovf = 1'b1;
            return WMAX;
        end
        return l.quo[W-1:0];
    endfunction

    // finish: sign, saturate, or pass a bypass result
    always_ff @(posedge clk)
    begin
        logic o;
        ctl_t c;
        if (advance)
        begin
            c = c_reg[NSTG];
            o = c.j.ovf;
            if (c.j.bypass)
            begin
                r_reg.res_re <= c.j.pre_re;
                r_reg.res_im <= c.j.pre_im;
            end
            else
            begin
                r_reg.res_re <= lane_fin(lr_reg[NSTG], c.dz0, o);
                r_reg.res_im <= lane_fin(li_reg[NSTG], c.dz0, o);
            end
            r_reg.div_by_zero <= c.j.dz;
            r_reg.overflow    <= o;
        end
    end

    assign res_valid = rv_reg;
    assign res       = r_reg;

endmodule

// ===== src/cau_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_fifo: result queue
// Holds finished items; reports its fill count and whether it is empty.
// ----------------------------------------------------------------------------
module cau_fifo import cau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  out_item_t wdata,
    input  logic      rd,
    output out_item_t rdata,
    output logic      empty,
    output logic [5:0] count
);

    localparam int DEPTH = 32;

    out_item_t    mem_reg [DEPTH];
    logic [4:0]   wp_reg, rp_reg;
    logic [5:0]   cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= wp_reg + 5'd1;
            end
            if (rd)
            begin
                rp_reg <= rp_reg + 5'd1;
            end
            cnt_reg <= cnt_reg + 6'(wr) - 6'(rd);
        end
    end

    // store the item
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    assign rdata = mem_reg[rp_reg];
    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;

endmodule

// ===== src/complex_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined complex ALU, Q16.16
// Add, subtract, multiply, divide and parallel combination with saturation.
// ----------------------------------------------------------------------------
// Channel   Ports                 Handshake
// input     in_item               push / full
// result    out_item              pop / empty
//
// One item per cycle enters while full is low; each passes 4 front stages,
// 13 divider stages and one output stage for every operation.
// The divider pipeline retires 4 quotient bits per stage over 48 bits.
// full rises when the result queue cannot take every item in flight.
// Reset clears valid flags, queue pointers and item counters only.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_item,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    localparam int LAT = 4 + NSTG + 2;

    logic      job_valid;
    job_t      job;
    logic      res_valid;
    out_item_t res;
    logic [5:0] count;
    logic [5:0] inflight_reg;
    logic      acc;
    logic      rd;

    assign acc = push && !full;
    assign rd  = pop && !empty;

    // count items between the input and the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_reg + 6'(acc) - 6'(res_valid);
        end
    end

    assign full = (6'(count) + inflight_reg) >= 6'd32;

    cau_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (acc),
        .in_item   (in_item),
        .advance   (1'b1),
        .job_valid (job_valid),
        .job       (job)
    );

    cau_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (1'b1),
        .job_valid (job_valid),
        .job       (job),
        .res_valid (res_valid),
        .res       (res)
    );

    cau_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_valid),
        .wdata (res),
        .rd    (rd),
        .rdata (out_item),
        .empty (empty),
        .count (count)
    );

    // queue never overruns
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> count < 6'd32)
        else $error("result queue overrun");

    // in-flight count bounded by pipeline depth
    assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 6'(LAT))
        else $error("in-flight count too large");

    // a divide-by-zero result carries the saturated real part
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.div_by_zero) |-> (res.res_re == WMAX && res.res_im == '0))
        else $error("bad divide-by-zero result");

endmodule

// ===== tb/cau_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_checker: result predictor and comparator for the complex ALU
// Watches accepted input items, computes the expected complex result with
// saturation and flags, queues it, and compares every popped result item.
// ----------------------------------------------------------------------------
module cau_checker import cau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  logic      full,
    input  in_item_t  in_item,
    input  logic      empty,
    input  logic      pop,
    input  out_item_t out_item,
    output int        fail_count,
    output int        pending,
    output int        results_seen
);

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    out_item_t expected_q[$];

    function automatic longint clamp(input longint x, inout logic ovf);
        if (x > QMAX) begin
            ovf = 1'b1;
            return QMAX;
        end
        if (x < QMIN) begin
            ovf = 1'b1;
            return QMIN;
        end
        return x;
    endfunction

    // Q16.16 product: exact, floor shift, saturate
    function automatic longint qmul(input longint x, input longint y, inout logic ovf);
        longint p;
        p = x * y;
        return clamp(p >>> FRAC, ovf);
    endfunction

    function automatic longint qquot(input longint n, input longint d, inout logic ovf);
        if (d == 0) begin
            if (n == 0)
                return 0;
            ovf = 1'b1;
            return (n > 0) ? QMAX : QMIN;
        end
        return clamp((n * 65536) / d, ovf);
    endfunction

    function automatic void cdiv(input longint ar, input longint ai, input longint br,
                                 input longint bi, output longint rr, output longint ri,
                                 inout logic dz, inout logic ovf);
        longint d;
        longint nr;
        longint ni;
        if (br == 0 && bi == 0) begin
            rr = QMAX;
            ri = 0;
            dz = 1'b1;
            return;
        end
        d  = clamp(qmul(br, br, ovf) + qmul(bi, bi, ovf), ovf);
        nr = clamp(qmul(ar, br, ovf) + qmul(ai, bi, ovf), ovf);
        ni = clamp(qmul(ai, br, ovf) - qmul(ar, bi, ovf), ovf);
        rr = qquot(nr, d, ovf);
        ri = qquot(ni, d, ovf);
    endfunction

    function automatic out_item_t complex_result(input in_item_t it);
        out_item_t r;
        longint ar;
        longint ai;
        longint br;
        longint bi;
        longint rr;
        longint ri;
        longint mr;
        longint mi;
        longint sr;
        longint si;
        logic dz;
        logic ovf;
        ar = it.a_re;
        ai = it.a_im;
        br = it.b_re;
        bi = it.b_im;
        rr = 0;
        ri = 0;
        dz = 1'b0;
        ovf = 1'b0;
        case (it.req_type)
            OP_ADD:
            begin
                rr = clamp(ar + br, ovf);
                ri = clamp(ai + bi, ovf);
            end
            OP_SUB:
            begin
                rr = clamp(ar - br, ovf);
                ri = clamp(ai - bi, ovf);
            end
            OP_MUL:
            begin
                rr = clamp(qmul(ar, br, ovf) - qmul(ai, bi, ovf), ovf);
                ri = clamp(qmul(ar, bi, ovf) + qmul(ai, br, ovf), ovf);
            end
            OP_DIV:
                cdiv(ar, ai, br, bi, rr, ri, dz, ovf);
            OP_PAR:
            begin
                mr = clamp(qmul(ar, br, ovf) - qmul(ai, bi, ovf), ovf);
                mi = clamp(qmul(ar, bi, ovf) + qmul(ai, br, ovf), ovf);
                sr = clamp(ar + br, ovf);
                si = clamp(ai + bi, ovf);
                cdiv(mr, mi, sr, si, rr, ri, dz, ovf);
            end
            default:
            begin
            end
        endcase
        r.res_re = rr[31:0];
        r.res_im = ri[31:0];
        r.div_by_zero = dz;
        r.overflow = ovf;
        return r;
    endfunction

    assign pending = expected_q.size();

    // Predict on accepted input items, compare on accepted result items
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n) begin
            if (push && !full)
                expected_q.push_back(complex_result(in_item));
            if (pop && !empty) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected result %h", out_item);
                end
                else begin
                    e = expected_q.pop_front();
                    if (e.res_re !== out_item.res_re || e.res_im !== out_item.res_im
                        || e.div_by_zero !== out_item.div_by_zero
                        || e.overflow !== out_item.overflow) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("ERROR: exp re=%h im=%h dz=%b ov=%b got re=%h im=%h dz=%b ov=%b",
                                     e.res_re, e.res_im, e.div_by_zero, e.overflow,
                                     out_item.res_re, out_item.res_im,
                                     out_item.div_by_zero, out_item.overflow);
                    end
                end
            end
        end
    end

    initial
    begin
        fail_count = 0;
        results_seen = 0;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the complex arithmetic unit
// Drives directed corner items then random bursts of mixed operations, with
// random result stalls and one long hold-off that fills the block.
// ----------------------------------------------------------------------------
module testbench;
    import cau_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  in_item;
    logic      empty;
    logic      pop;
    out_item_t out_item;
    int        fail_count;
    int        pending;
    int        results_seen;
    int        sent;
    int        hold_off;

    complex_arithmetic_unit uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item)
    );

    cau_checker checker_i (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item), .fail_count(fail_count),
        .pending(pending), .results_seen(results_seen)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Pick an operand value: corners, small values, or full random
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'h00010000;
            4: return 32'hffff0000;
            5, 6: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t make_item(input logic [2:0] op, input logic [31:0] ar,
                                           input logic [31:0] ai, input logic [31:0] br,
                                           input logic [31:0] bi);
        in_item_t it;
        it.req_type = op;
        it.a_re = ar;
        it.a_im = ai;
        it.b_re = br;
        it.b_im = bi;
        return it;
    endfunction

    // Offer one item and hold it until accepted
    task automatic send_item(input in_item_t it);
        push <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent++;
    endtask

    task automatic idle_gap(input int n);
        push <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Result side: random stalls, with one long hold-off mid run
    initial
    begin
        pop = 1'b0;
        hold_off = 0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (sent >= 300 && hold_off == 0) begin
                pop <= 1'b0;
                repeat (200) @(posedge clk);
                hold_off = 1;
            end
            if ((sent / 60) % 3 == 1)
                pop <= 1'b1;
            else
                pop <= ($urandom_range(0, 3) != 0);
        end
    end

    // Stimulus
    initial
    begin
        logic [2:0] op;
        int burst;
        in_item_t pair;
        push = 1'b0;
        in_item = '0;
        rst_n = 1'b0;
        sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: every operation, zero divisors, overflow, unused codes
        send_item(make_item(OP_ADD, 32'h7fffffff, 32'h80000000, 32'h1, 32'hffffffff));
        send_item(make_item(OP_SUB, 32'h80000000, 32'h7fffffff, 32'h1, 32'hffffffff));
        send_item(make_item(OP_ADD, 32'h00010000, 32'h00020000, 32'hffff0000, 32'h0));
        send_item(make_item(OP_MUL, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
        send_item(make_item(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
        send_item(make_item(OP_MUL, 32'hffffffff, 32'h1, 32'h1, 32'h1));
        send_item(make_item(OP_DIV, 32'h00010000, 32'h0, 32'h0, 32'h0));
        send_item(make_item(OP_DIV, 32'h00030000, 32'h00020000, 32'h00010000, 32'h00010000));
        send_item(make_item(OP_DIV, 32'h00010000, 32'hffff0000, 32'h1, 32'h0));
        send_item(make_item(OP_DIV, 32'h0, 32'h0, 32'h1, 32'h1));
        send_item(make_item(OP_DIV, 32'h80000000, 32'h7fffffff, 32'h00000100, 32'h0));
        send_item(make_item(OP_DIV, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000));
        send_item(make_item(OP_PAR, 32'h00010000, 32'h0, 32'hffff0000, 32'h0));
        send_item(make_item(OP_PAR, 32'h00020000, 32'h00010000, 32'h00010000, 32'h00030000));
        send_item(make_item(OP_PAR, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        send_item(make_item(OP_PAR, 32'h00010000, 32'h0, 32'h00000001, 32'h0));
        send_item(make_item(3'd5, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff));
        send_item(make_item(3'd6, 32'h1, 32'h1, 32'h1, 32'h1));
        send_item(make_item(3'd7, 32'h7fffffff, 32'h0, 32'h0, 32'h0));

        // Random bursts with gaps; some stretches without gaps
        while (sent < 770) begin
            burst = $urandom_range(1, 30);
            repeat (burst) begin
                op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
                if (op == OP_PAR && $urandom_range(0, 5) == 0) begin
                    pair = make_item(op, pick_word(), pick_word(), 32'h0, 32'h0);
                    send_item(make_item(op, pair.a_re, pair.a_im,
                                        -pair.a_re, -pair.a_im));
                end
                else if (op == OP_DIV && $urandom_range(0, 7) == 0)
                    send_item(make_item(op, pick_word(), pick_word(), 32'h0, 32'h0));
                else
                    send_item(make_item(op, pick_word(), pick_word(),
                                        pick_word(), pick_word()));
            end
            if ((sent / 100) % 2 == 0)
                idle_gap($urandom_range(0, 12));
        end
        push <= 1'b0;

        wait (pending == 0);
        repeat (40) @(posedge clk);
        $display("Sent %0d items over all five operations and unused codes,", sent);
        $display("checked %0d results including zero divisors and saturation.", results_seen);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
